// ===== rtl/cbm_pkg.sv =====
// Package for the cartridge bank mapper with clock.
// Holds operation and target codes, clock register selects and the structs
// passed between the mapper decode and the clock unit. No dependencies.
package cbm_pkg;

  localparam int unsigned ROM_BANK_BITS  = 7;
  localparam int unsigned RAM_BANKS      = 4;
  localparam int unsigned BOOT_ROM_BYTES = 256;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned MAPPED_W = 21;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [3:0] ENABLE_KEY = 4'hA;
  localparam logic [7:0] SEC_LIMIT  = 8'd60;
  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;

  typedef enum logic [2:0] {
    OP_ROM_READ  = 3'd0,
    OP_MAP_WRITE = 3'd1,
    OP_RAM_READ  = 3'd2,
    OP_RAM_WRITE = 3'd3,
    OP_TICK      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    TGT_BOOT = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_RTC  = 3'd3,
    TGT_NONE = 3'd4
  } tgt_e;

  // clock register selects
  localparam logic [7:0] RTC_SEC  = 8'h08;
  localparam logic [7:0] RTC_MIN  = 8'h09;
  localparam logic [7:0] RTC_HOUR = 8'h0A;
  localparam logic [7:0] RTC_DAYL = 8'h0B;
  localparam logic [7:0] RTC_CTL  = 8'h0C;

  // mapper register windows (address bits 15:13)
  localparam logic [2:0] WIN_ENABLE = 3'd0;
  localparam logic [2:0] WIN_ROMBNK = 3'd1;
  localparam logic [2:0] WIN_SELECT = 3'd2;
  localparam logic [2:0] WIN_LATCH  = 3'd3;

  typedef struct packed {
    logic       tick;
    logic       latch;
    logic       wr_en;
    logic [7:0] sel;
    logic [7:0] wr_data;
  } rtc_cmd_t;

  typedef struct packed {
    tgt_e                  target;
    logic [MAPPED_W-1:0]   mapped;
    logic [7:0]            rtc_data;
    logic                  strobe;
    logic [7:0]            store;
  } result_t;

endpackage

// ===== rtl/cbm_rtc.sv =====
// Real-time clock: second/minute/hour/day counters, control byte, latch copy.
// Driven by commands from cbm_map; depends on cbm_pkg.
module cbm_rtc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  cbm_pkg::rtc_cmd_t cmd_i,
  output logic [7:0]        rd_data_o
);
  import cbm_pkg::*;

  logic [7:0]  sec_q, sec_d, min_q, min_d, hour_q, hour_d, ctl_q, ctl_d;
  logic [8:0]  day_q, day_d;
  logic [40:0] latched_q, latched_d;

  logic [7:0] sec_inc, min_inc, hour_inc;
  logic [9:0] day_inc;
  logic       sec_wrap, min_wrap, hour_wrap, day_wrap;

  always_comb begin
    sec_inc   = sec_q + 8'd1;
    min_inc   = min_q + 8'd1;
    hour_inc  = hour_q + 8'd1;
    day_inc   = {1'b0, day_q} + 10'd1;
    sec_wrap  = (sec_inc >= SEC_LIMIT) || (sec_inc == 8'd0);
    min_wrap  = (min_inc >= MIN_LIMIT) || (min_inc == 8'd0);
    hour_wrap = (hour_inc >= HOUR_LIMIT) || (hour_inc == 8'd0);
    day_wrap  = day_inc[9];
  end

  always_comb begin
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    day_d     = day_q;
    ctl_d     = ctl_q;
    latched_d = latched_q;
    if (fire_i) begin
      if (cmd_i.tick) begin
        sec_d = sec_wrap ? 8'd0 : sec_inc;
        if (sec_wrap) begin
          min_d = min_wrap ? 8'd0 : min_inc;
          if (min_wrap) begin
            hour_d = hour_wrap ? 8'd0 : hour_inc;
            if (hour_wrap) begin
              day_d = day_inc[8:0];
              if (day_wrap) begin
                ctl_d[7] = 1'b1;
              end
            end
          end
        end
        ctl_d[0] = day_d[8];
      end
      if (cmd_i.latch) begin
        latched_d = {ctl_q, day_q, hour_q, min_q, sec_q};
      end
      if (cmd_i.wr_en) begin
        case (cmd_i.sel)
          RTC_SEC:  sec_d = cmd_i.wr_data;
          RTC_MIN:  min_d = cmd_i.wr_data;
          RTC_HOUR: hour_d = cmd_i.wr_data;
          RTC_DAYL: day_d = {day_q[8], cmd_i.wr_data};
          default: begin
            ctl_d = cmd_i.wr_data;
            day_d = {cmd_i.wr_data[0], day_q[7:0]};
          end
        endcase
      end
    end
  end

  always_comb begin
    case (cmd_i.sel)
      RTC_SEC:  rd_data_o = latched_q[7:0];
      RTC_MIN:  rd_data_o = latched_q[15:8];
      RTC_HOUR: rd_data_o = latched_q[23:16];
      RTC_DAYL: rd_data_o = latched_q[31:24];
      default:  rd_data_o = latched_q[40:33];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      day_q     <= '0;
      ctl_q     <= '0;
      latched_q <= '0;
    end else begin
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      day_q     <= day_d;
      ctl_q     <= ctl_d;
      latched_q <= latched_d;
    end
  end

endmodule

// ===== rtl/cbm_map.sv =====
// Mapper registers and access decode: ROM/boot/RAM/RTC targeting and clock
// commands. Depends on cbm_pkg; reads latched clock bytes from cbm_rtc.
module cbm_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [2:0]                op_i,
  input  logic [cbm_pkg::ADDR_W-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  input  logic                      boot_i,
  input  logic [7:0]                rtc_rd_data_i,
  output cbm_pkg::result_t          res_o,
  output cbm_pkg::rtc_cmd_t         cmd_o
);
  import cbm_pkg::*;

  logic [ROM_BANK_BITS-1:0] bank_q, bank_d, bank_eff;
  logic [3:0]               enable_q, enable_d;
  logic [7:0]               sel_q, sel_d, latch_prev_q, latch_prev_d;
  logic                     enabled, is_ram, is_rtc;

  always_comb begin
    enabled  = (enable_q == ENABLE_KEY);
    is_ram   = (sel_q < 8'(RAM_BANKS));
    is_rtc   = (sel_q >= RTC_SEC) && (sel_q <= RTC_CTL);
    bank_eff = (bank_q == '0) ? ROM_BANK_BITS'(1) : bank_q;
  end

  always_comb begin
    res_o          = '0;
    res_o.target   = TGT_NONE;
    cmd_o          = '0;
    cmd_o.sel      = sel_q;
    cmd_o.wr_data  = wdata_i;
    bank_d         = bank_q;
    enable_d       = enable_q;
    sel_d          = sel_q;
    latch_prev_d   = latch_prev_q;
    case (op_i)
      OP_ROM_READ: begin
        if (boot_i && (addr_i < ADDR_W'(BOOT_ROM_BYTES))) begin
          res_o.target = TGT_BOOT;
          res_o.mapped = MAPPED_W'(addr_i);
        end else begin
          res_o.target = TGT_ROM;
          res_o.mapped = MAPPED_W'(addr_i);
          if (addr_i[15:14] != 2'b00) begin
            res_o.mapped = MAPPED_W'({bank_eff, addr_i[13:0]});
          end
        end
      end
      OP_MAP_WRITE: begin
        case (addr_i[15:13])
          WIN_ENABLE: enable_d = wdata_i[3:0];
          WIN_ROMBNK: bank_d = ROM_BANK_BITS'(wdata_i & 8'h7F);
          WIN_SELECT: sel_d = wdata_i;
          WIN_LATCH: begin
            cmd_o.latch  = (latch_prev_q == 8'h00) && (wdata_i == 8'h01);
            latch_prev_d = wdata_i;
          end
          default: ;
        endcase
      end
      OP_RAM_READ, OP_RAM_WRITE: begin
        if (enabled && is_ram) begin
          res_o.target = TGT_RAM;
          res_o.mapped = MAPPED_W'({sel_q, addr_i[12:0]});
          if (op_i == OP_RAM_WRITE) begin
            res_o.strobe = 1'b1;
            res_o.store  = wdata_i;
          end
        end else if (enabled && is_rtc) begin
          res_o.target = TGT_RTC;
          if (op_i == OP_RAM_READ) begin
            res_o.rtc_data = rtc_rd_data_i;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      OP_TICK: cmd_o.tick = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q       <= '0;
      enable_q     <= '0;
      sel_q        <= '0;
      latch_prev_q <= '0;
    end else if (fire_i) begin
      bank_q       <= bank_d;
      enable_q     <= enable_d;
      sel_q        <= sel_d;
      latch_prev_q <= latch_prev_d;
    end
  end

endmodule

// ===== rtl/cartridge_bank_mapper_with_rtc.sv =====
// Top level of the cartridge bank mapper with real-time clock.
// Input register, cbm_map decode, cbm_rtc clock, result register.
// Depends on cbm_pkg, cbm_map, cbm_rtc.
//
//   channel  | dir | handshake                    | payload
//   ---------+-----+------------------------------+--------------------------------
//   s_axis   | in  | s_axis_tvalid_i/tready_o     | tuser: operation; tdata: addr,
//            |     |                              |   write byte, boot overlay flag
//   m_axis   | out | m_axis_tvalid_o/tready_i     | tuser: target; tdata: mapped
//            |     |                              |   offset, rtc byte, strobe, store
//
// One in, one out via the input and result registers; one per cycle unless stalled.
// Mapper and clock state update as the item leaves the input register.
// Reset clears all mapper and clock registers; both stages come up empty.
// Input is taken while the result register holds a stalled transaction, as
// long as the input register is empty.
module cartridge_bank_mapper_with_rtc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] address, [23:16] write_data, [24] boot_rom_mapped, [31:25] zero
  input  logic [cbm_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [20:0] mapped_address, [28:21] rtc_data, [29] ram_write_strobe,
  // [37:30] store_data, [39:38] zero
  output logic [cbm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // [2:0] target
  output logic [2:0]                          m_axis_tuser_o
);
  import cbm_pkg::*;

  logic              in_vld_q;
  logic [2:0]        op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [7:0]        wdata_q;
  logic              boot_q;
  logic              out_vld_q;
  result_t           res_q, res_d;
  rtc_cmd_t          cmd;
  logic [7:0]        rtc_rd;
  logic              fire, s_fire;

  assign fire            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || fire;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q    <= s_axis_tuser_i;
      addr_q  <= s_axis_tdata_i[15:0];
      wdata_q <= s_axis_tdata_i[23:16];
      boot_q  <= s_axis_tdata_i[24];
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  cbm_map u_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .op_i          (op_q),
    .addr_i        (addr_q),
    .wdata_i       (wdata_q),
    .boot_i        (boot_q),
    .rtc_rd_data_i (rtc_rd),
    .res_o         (res_d),
    .cmd_o         (cmd)
  );

  cbm_rtc u_rtc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cmd_i     (cmd),
    .rd_data_o (rtc_rd)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_q.target;
  assign m_axis_tdata_o  = {2'b00, res_q.store, res_q.strobe, res_q.rtc_data, res_q.mapped};

endmodule

// ===== rtl/cbm_checker.sv =====
// Port-level checker for cartridge_bank_mapper_with_rtc, bound to the top.
// Depends on cbm_pkg.
module cbm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [cbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [2:0]                      m_axis_tuser_o
);
  import cbm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // ram strobe only on a cartridge ram target
  a_strobe_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[29] |-> m_axis_tuser_o == TGT_RAM)
    else $error("strobe without ram target");

  // clock byte only on an rtc target
  a_rtc_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[28:21] != 8'h00) |-> m_axis_tuser_o == TGT_RTC)
    else $error("rtc data outside rtc target");

  // boot overlay offsets stay inside the boot rom
  a_boot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == TGT_BOOT |-> m_axis_tdata_o[20:8] == 13'd0)
    else $error("boot offset out of range");

  // result valid after the input and result registers with an open sink
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && m_axis_tready_i ##1 m_axis_tready_i
      |=> m_axis_tvalid_o)
    else $error("result missing after two cycles");

endmodule

bind cartridge_bank_mapper_with_rtc cbm_checker u_cbm_checker (.*);
